/* sv/rpc_pkg.sv */
package rpc_pkg;

    localparam int MAX_TOTAL = 64;
    localparam int TOTAL_W   = 7;
    localparam int COUNT_W   = 21;
    localparam int DEPTH     = MAX_TOTAL + 1;
    localparam int ADDR_W    = $clog2(DEPTH);
    // counters run one past the last entry
    localparam int CNT_W     = $clog2(MAX_TOTAL + 2);

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UC_IDLE  = 3'd0;
    localparam upc_t UC_CHECK = 3'd1;
    localparam upc_t UC_CLEAR = 3'd2;
    localparam upc_t UC_ROW   = 3'd3;
    localparam upc_t UC_INNER = 3'd4;
    localparam upc_t UC_DRAIN = 3'd5;
    localparam upc_t UC_READ  = 3'd6;
    localparam upc_t UC_OUT   = 3'd7;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NOT_START,
        COND_ZERO,
        COND_S_NE_TOTAL,
        COND_P_NE_LIMIT
    } cond_t;

    typedef enum logic [1:0] {
        S_HOLD,
        S_ZERO,
        S_INC,
        S_LOAD_P
    } s_op_t;

    typedef enum logic [1:0] {
        P_HOLD,
        P_ONE,
        P_INC
    } p_op_t;

    typedef struct packed {
        logic  load_in;
        s_op_t s_op;
        p_op_t p_op;
        logic  clear_we;
        logic  issue;
        logic  rd_total;
        logic  done;
    } ctrl_t;

    typedef struct packed {
        logic zero;
        logic s_at_total;
        logic p_at_limit;
    } status_t;

    typedef struct packed {
        cond_t cond;
        upc_t  target;
        ctrl_t ctrl;
    } ucode_t;

    function automatic ucode_t uc_rom(input upc_t upc);
        ucode_t w;
        w = '0;
        unique case (upc)
            UC_IDLE:
            begin
                w.ctrl.load_in = 1'b1;
                w.ctrl.s_op    = S_ZERO;
                w.ctrl.p_op    = P_ONE;
                w.cond         = COND_NOT_START;
                w.target       = UC_IDLE;
            end
            UC_CHECK:
            begin
                w.cond   = COND_ZERO;
                w.target = UC_OUT;
            end
            UC_CLEAR:
            begin
                w.ctrl.clear_we = 1'b1;
                w.ctrl.s_op     = S_INC;
                w.cond          = COND_S_NE_TOTAL;
                w.target        = UC_CLEAR;
            end
            UC_ROW:
            begin
                w.ctrl.s_op = S_LOAD_P;
            end
            UC_INNER:
            begin
                w.ctrl.issue = 1'b1;
                w.ctrl.s_op  = S_INC;
                w.cond       = COND_S_NE_TOTAL;
                w.target     = UC_INNER;
            end
            UC_DRAIN:
            begin
                w.ctrl.p_op = P_INC;
                w.cond      = COND_P_NE_LIMIT;
                w.target    = UC_ROW;
            end
            UC_READ:
            begin
                w.ctrl.rd_total = 1'b1;
            end
            UC_OUT:
            begin
                w.ctrl.done = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = UC_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = UC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/rpc_seq.sv */
module rpc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rpc_pkg::status_t status,
    output rpc_pkg::ctrl_t   ctrl,
    output logic             busy
);

    rpc_pkg::upc_t   upc_reg;
    rpc_pkg::upc_t   upc_next;
    rpc_pkg::ucode_t word;
    logic            take;

    assign word = rpc_pkg::uc_rom(upc_reg);
    assign ctrl = word.ctrl;
    assign busy = (upc_reg != rpc_pkg::UC_IDLE);

    always_comb
    begin
        unique case (word.cond)
            rpc_pkg::COND_NONE:       take = 1'b0;
            rpc_pkg::COND_ALWAYS:     take = 1'b1;
            rpc_pkg::COND_NOT_START:  take = !start;
            rpc_pkg::COND_ZERO:       take = status.zero;
            rpc_pkg::COND_S_NE_TOTAL: take = !status.s_at_total;
            rpc_pkg::COND_P_NE_LIMIT: take = !status.p_at_limit;
            default:                  take = 1'b0;
        endcase
    end

    assign upc_next = take ? word.target : upc_reg + rpc_pkg::upc_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= rpc_pkg::UC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* sv/rpc_datapath.sv */
module rpc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpc_pkg::ctrl_t               ctrl,
    input  logic [rpc_pkg::TOTAL_W-1:0]  total,
    input  logic [rpc_pkg::TOTAL_W-1:0]  largest_part,
    output rpc_pkg::status_t             status,
    output logic [rpc_pkg::COUNT_W-1:0]  partition_count,
    output logic                         done
);

    localparam int AW = rpc_pkg::ADDR_W;
    localparam int CW = rpc_pkg::CNT_W;
    localparam int NW = rpc_pkg::COUNT_W;

    logic [NW-1:0] mem [rpc_pkg::DEPTH];

    logic [AW-1:0] total_reg;
    logic [AW-1:0] limit_reg;
    logic          zero_reg;
    logic [CW-1:0] s_reg;
    logic [CW-1:0] s_next;
    logic [CW-1:0] p_reg;
    logic [CW-1:0] p_next;

    logic          pend_valid_reg;
    logic [AW-1:0] pend_addr_reg;
    logic [NW-1:0] rd_a_reg;
    logic [NW-1:0] rd_b_reg;
    logic          fwd_a_reg;
    logic          fwd_b_reg;
    logic [NW-1:0] fwd_data_reg;
    logic [NW-1:0] count_reg;
    logic          done_reg;

    logic [rpc_pkg::TOTAL_W-1:0] limit_clamped;
    logic                        in_zero;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [CW-1:0] s_minus_p;
    logic          we;
    logic [AW-1:0] waddr;
    logic [NW-1:0] wdata;
    logic [NW-1:0] op_a;
    logic [NW-1:0] op_b;
    logic [NW-1:0] sum;

    assign limit_clamped = (largest_part > total) ? total : largest_part;
    assign in_zero = (total == '0) || (largest_part == '0)
                  || (total > rpc_pkg::TOTAL_W'(rpc_pkg::MAX_TOTAL));

    assign status.zero       = zero_reg;
    assign status.s_at_total = (s_reg == CW'(total_reg));
    assign status.p_at_limit = (p_reg == CW'(limit_reg));

    // operands are registered from the read, bypassing a same-cycle write
    assign op_a = fwd_a_reg ? fwd_data_reg : rd_a_reg;
    assign op_b = fwd_b_reg ? fwd_data_reg : rd_b_reg;
    assign sum  = op_a + op_b;

    assign s_minus_p = s_reg - p_reg;
    assign raddr_a   = ctrl.rd_total ? total_reg : s_reg[AW-1:0];
    assign raddr_b   = s_minus_p[AW-1:0];

    assign we    = ctrl.clear_we || pend_valid_reg;
    assign waddr = pend_valid_reg ? pend_addr_reg : s_reg[AW-1:0];
    assign wdata = pend_valid_reg ? sum
                 : ((s_reg == '0) ? NW'(1) : '0);

    always_comb
    begin
        unique case (ctrl.s_op)
            rpc_pkg::S_HOLD:   s_next = s_reg;
            rpc_pkg::S_ZERO:   s_next = '0;
            rpc_pkg::S_INC:    s_next = s_reg + CW'(1);
            rpc_pkg::S_LOAD_P: s_next = p_reg;
            default:           s_next = s_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.p_op)
            rpc_pkg::P_HOLD: p_next = p_reg;
            rpc_pkg::P_ONE:  p_next = CW'(1);
            rpc_pkg::P_INC:  p_next = p_reg + CW'(1);
            default:         p_next = p_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg     <= mem[raddr_a];
        rd_b_reg     <= mem[raddr_b];
        fwd_a_reg    <= we && (waddr == raddr_a);
        fwd_b_reg    <= we && (waddr == raddr_b);
        fwd_data_reg <= wdata;
        pend_addr_reg <= s_reg[AW-1:0];
        if (ctrl.load_in)
        begin
            total_reg <= total[AW-1:0];
            limit_reg <= limit_clamped[AW-1:0];
        end
        if (ctrl.done)
        begin
            count_reg <= zero_reg ? '0 : op_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg          <= '0;
            p_reg          <= '0;
            zero_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            s_reg          <= s_next;
            p_reg          <= p_next;
            pend_valid_reg <= ctrl.issue;
            done_reg       <= ctrl.done;
            if (ctrl.load_in)
            begin
                zero_reg <= in_zero;
            end
        end
    end

    assign partition_count = count_reg;
    assign done            = done_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result beat longer than one cycle");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear_we |-> !pend_valid_reg)
        else $error("clear write collides with update write");

    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.issue |-> (s_reg >= p_reg) && (s_reg <= CW'(total_reg)))
        else $error("update index out of row range");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) && $past(zero_reg) |-> (count_reg == '0))
        else $error("out-of-range item gave nonzero count");
`endif

endmodule

/* sv/restricted_partition_counter.sv */
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// item in   | total[6:0], largest_part[6:0]           | accepted when start && !busy
// result    | partition_count[20:0]                   | done high for one cycle
//
// one item at a time: clear entries 0..T, then for p=1..L update entries p..T,
// then read entry T, for total T and clamped limit L
// the inner row loop makes a single table update per cycle
// zero or out-of-range items skip the table and go straight to the result
// rst_n clears the step counter; the scratch table is rebuilt for each in-range item
// done cannot be held off; the next item may start while a result is shown
module restricted_partition_counter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rpc_pkg::TOTAL_W-1:0] total,
    input  logic [rpc_pkg::TOTAL_W-1:0] largest_part,
    output logic                        done,
    output logic [rpc_pkg::COUNT_W-1:0] partition_count
);

    rpc_pkg::ctrl_t   ctrl;
    rpc_pkg::status_t status;

    rpc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    rpc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .total           (total),
        .largest_part    (largest_part),
        .status          (status),
        .partition_count (partition_count),
        .done            (done)
    );

endmodule

/* sim/partition_count_checker.sv */
`timescale 1ns / 1ps

module partition_count_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [rpc_pkg::TOTAL_W-1:0] total,
    input  logic [rpc_pkg::TOTAL_W-1:0] largest_part,
    input  logic                        done,
    input  logic [rpc_pkg::COUNT_W-1:0] partition_count,
    output int                          mismatches,
    output int                          pending
);

    localparam int QUEUE_DEPTH = 8;

    logic [rpc_pkg::COUNT_W-1:0] wanted_counts [QUEUE_DEPTH];
    int                          rd_idx      = 0;
    int                          wr_idx      = 0;
    int                          fill        = 0;
    int                          errors      = 0;
    int                          fill_seen   = 0;
    int                          errors_seen = 0;

    assign pending    = fill_seen;
    assign mismatches = errors_seen;

    // bottom-up table over part sizes, entries wrap at the count width
    function automatic logic [rpc_pkg::COUNT_W-1:0] count_bounded_partitions(
        input logic [rpc_pkg::TOTAL_W-1:0] n,
        input logic [rpc_pkg::TOTAL_W-1:0] cap
    );
        logic [rpc_pkg::COUNT_W-1:0] ways [0:rpc_pkg::MAX_TOTAL];
        int                          lim;
        if (n == 0 || cap == 0 || n > rpc_pkg::MAX_TOTAL)
            return '0;
        lim = (cap > n) ? n : cap;
        ways[0] = rpc_pkg::COUNT_W'(1);
        for (int s = 1; s <= n; s++)
            ways[s] = '0;
        for (int p = 1; p <= lim; p++)
            for (int s = p; s <= n; s++)
                ways[s] = ways[s] + ways[s - p];
        return ways[n];
    endfunction

    always @(posedge clk)
    begin
        logic [rpc_pkg::COUNT_W-1:0] want;
        if (rst_n)
        begin
            // result beat belongs to an earlier item, so check it first
            if (done)
            begin
                if (fill == 0)
                begin
                    $error("partition_count: expected no result, got %0d", partition_count);
                    errors = errors + 1;
                end
                else
                begin
                    want   = wanted_counts[rd_idx];
                    rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
                    fill   = fill - 1;
                    if (partition_count !== want)
                    begin
                        $error("partition_count: expected %0d, got %0d", want, partition_count);
                        errors = errors + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                if (fill == QUEUE_DEPTH)
                begin
                    $error("partition_count: expected at most %0d beats in flight, got %0d",
                           QUEUE_DEPTH, fill + 1);
                    errors = errors + 1;
                end
                else
                begin
                    wanted_counts[wr_idx] = count_bounded_partitions(total, largest_part);
                    wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
                    fill   = fill + 1;
                end
            end
            fill_seen   <= fill;
            errors_seen <= errors;
        end
    end

endmodule

/* sim/tb_restricted_partition_counter.sv */
`timescale 1ns / 1ps

module tb_restricted_partition_counter;

    localparam int RANDOM_ITEMS = 250;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 2300;

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        start        = 1'b0;
    logic [rpc_pkg::TOTAL_W-1:0] total        = '0;
    logic [rpc_pkg::TOTAL_W-1:0] largest_part = '0;
    logic                        busy;
    logic                        done;
    logic [rpc_pkg::COUNT_W-1:0] partition_count;
    int                          mismatches;
    int                          pending;
    int                          idle_pct     = 6;
    int                          quiet_cycles = 0;

    restricted_partition_counter uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .total           (total),
        .largest_part    (largest_part),
        .done            (done),
        .partition_count (partition_count)
    );

    partition_count_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .total           (total),
        .largest_part    (largest_part),
        .done            (done),
        .partition_count (partition_count),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ends the run when neither an item nor a result moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // returns at the edge that accepts the beat, start still high
    task automatic send_item(
        input logic [rpc_pkg::TOTAL_W-1:0] t,
        input logic [rpc_pkg::TOTAL_W-1:0] l
    );
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        total        <= t;
        largest_part <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic [rpc_pkg::TOTAL_W-1:0] t;
        logic [rpc_pkg::TOTAL_W-1:0] l;
        int                          sel;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero operands, full range, limit above total, out of range totals
        send_item(0, 0);
        send_item(0, 5);
        send_item(5, 0);
        send_item(0, 127);
        send_item(1, 1);
        send_item(1, 127);
        send_item(2, 2);
        send_item(3, 1);
        send_item(7, 3);
        send_item(10, 20);
        send_item(63, 64);
        send_item(64, 1);
        send_item(64, 32);
        send_item(64, 63);
        send_item(64, 64);
        send_item(64, 127);
        send_item(65, 3);
        send_item(100, 50);
        send_item(127, 0);
        send_item(127, 1);
        send_item(127, 127);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
                idle_pct = 87;
            else if (i == 2 * RANDOM_ITEMS / 3)
                idle_pct = 0;
            sel = $urandom_range(99);
            // mostly small totals to keep the run short
            if (sel < 60)
            begin
                t = rpc_pkg::TOTAL_W'($urandom_range(20));
                l = rpc_pkg::TOTAL_W'($urandom_range(t + 3));
            end
            else if (sel < 85)
            begin
                t = rpc_pkg::TOTAL_W'($urandom_range(rpc_pkg::MAX_TOTAL));
                l = rpc_pkg::TOTAL_W'($urandom_range(rpc_pkg::MAX_TOTAL));
            end
            else if (sel < 95)
            begin
                t = rpc_pkg::TOTAL_W'($urandom_range(127, rpc_pkg::MAX_TOTAL + 1));
                l = rpc_pkg::TOTAL_W'($urandom_range(127));
            end
            else
            begin
                t = rpc_pkg::TOTAL_W'($urandom_range(rpc_pkg::MAX_TOTAL));
                l = rpc_pkg::TOTAL_W'($urandom_range(127));
            end
            send_item(t, l);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* restricted_partition_counter.f */
sv/rpc_pkg.sv
sv/rpc_seq.sv
sv/rpc_datapath.sv
sv/restricted_partition_counter.sv
sim/partition_count_checker.sv
sim/tb_restricted_partition_counter.sv
